// ===== src/bfa_pkg.sv =====
// Package for the best-fit heap allocator.
// Holds field widths, parameter defaults, status codes, sequencer states
// and the control struct shared by the top level and the best-fit tracker.
package bfa_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 4 * 1024;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned MAX_BLOCKS_DEF   = 64;

  localparam int unsigned REQ_W  = 12;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OFF_W  = 12;

  typedef enum logic [STAT_W-1:0] {
    STAT_GRANT = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2
  } bfa_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_WRITE
  } bfa_state_e;

  typedef struct packed {
    logic clr;       // start of a new search
    logic cand_vld;  // a table entry is presented this cycle
  } bfa_trk_ctrl_t;

endpackage

// ===== src/bfa_best_track.sv =====
// Best-fit tracker: the shared compare unit of the allocator.
// Compares one table entry per cycle against the best candidate so far.
// Depends on bfa_pkg.
module bfa_best_track import bfa_pkg::*; #(
  parameter int unsigned ARENA_BYTES = ARENA_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS  = MAX_BLOCKS_DEF,
  localparam int unsigned AW = $clog2(ARENA_BYTES),
  localparam int unsigned IW = $clog2(MAX_BLOCKS),
  localparam int unsigned CW = ((AW > REQ_W) ? AW : REQ_W) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfa_trk_ctrl_t ctrl_i,
  input  logic [CW-1:0] need_i,
  input  logic [AW-1:0] cand_size_i,
  input  logic [AW-1:0] cand_off_i,
  input  logic [IW-1:0] cand_idx_i,
  input  logic          cand_used_i,
  output logic          found_o,
  output logic [AW-1:0] best_size_o,
  output logic [AW-1:0] best_off_o,
  output logic [IW-1:0] best_idx_o
);

  logic          found_q, found_d;
  logic [AW-1:0] size_q, off_q;
  logic [IW-1:0] idx_q;
  logic          fits, take;

  always_comb begin
    fits = !cand_used_i && (CW'(cand_size_i) >= need_i);
    // Ties on size go to the higher offset.
    take = ctrl_i.cand_vld && fits &&
           (!found_q || (cand_size_i < size_q) ||
            ((cand_size_i == size_q) && (cand_off_i > off_q)));
    found_d = ctrl_i.clr ? 1'b0 : (found_q || take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      size_q <= cand_size_i;
      off_q  <= cand_off_i;
      idx_q  <= cand_idx_i;
    end
  end

  assign found_o     = found_q;
  assign best_size_o = size_q;
  assign best_off_o  = off_q;
  assign best_idx_o  = idx_q;

  a_no_clr_and_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.clr && ctrl_i.cand_vld))
    else $error("tracker cleared while a candidate is presented");

  a_take_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> found_q)
    else $error("accepted candidate did not set found");

  a_found_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !ctrl_i.clr) |=> (CW'(size_q) >= $past(need_i)))
    else $error("best candidate smaller than the need");

endmodule

// ===== src/best_fit_heap_allocator.sv =====
// Best-fit heap allocator: one request item in, one result item out.
// The item is accepted in the idle state; the sequencer then reads one table entry per
// scan step, drains the read pipeline and decides; the result is registered on decide.
// A new item is taken only back in the idle state; a grant adds a second table write
// after the decide step, and the decide step waits while the output is stalled.
// Reset is asynchronous, active low; it restores one free block at offset 0 at once.
module best_fit_heap_allocator import bfa_pkg::*; #(
  parameter int unsigned ARENA_BYTES  = ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [REQ_W-1:0] req_size_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [OFF_W-1:0] payload_offset_o
);

  localparam int unsigned AW   = $clog2(ARENA_BYTES);
  localparam int unsigned IW   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW   = ((AW > REQ_W) ? AW : REQ_W) + 1;
  localparam logic [AW-1:0]   INIT_SIZE = AW'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [CNTW-1:0] CNT_MAX   = CNTW'(MAX_BLOCKS);

  bfa_state_e        state_q, state_d;
  logic [REQ_W-1:0]  req_q;
  logic [CNTW-1:0]   idx_q, idx_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic [MAX_BLOCKS-1:0] used_q;
  logic              e0_init_q;
  logic              p_vld_q, p_vld_d;
  logic [IW-1:0]     p_idx_q;
  logic              rd_en;

  logic [AW-1:0]     off_mem [MAX_BLOCKS];
  logic [AW-1:0]     size_mem [MAX_BLOCKS];
  logic [AW-1:0]     rd_off_q, rd_size_q;
  logic              rd_used_q, rd_init_q;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [AW-1:0]     wdata_off, wdata_size;

  logic              out_vld_q, out_vld_d, out_load;
  bfa_status_e       status_q, status_d;
  logic [OFF_W-1:0]  pay_q, pay_d;

  bfa_trk_ctrl_t     trk_ctrl;
  logic              found;
  logic [AW-1:0]     best_size, best_off;
  logic [IW-1:0]     best_idx;

  logic [CW-1:0]     need, rest, hdr, pay_full;
  logic [AW-1:0]     cand_size;

  assign need      = CW'(req_q) + CW'(HEADER_BYTES);
  assign rest      = CW'(best_size) - need;
  assign hdr       = CW'(best_off) + CW'(best_size) - CW'(req_q);
  assign pay_full  = hdr + CW'(HEADER_BYTES);
  // Entry 0 reads as the initial free block until it is first written.
  assign cand_size = rd_init_q ? INIT_SIZE : rd_size_q;

  bfa_best_track #(
    .ARENA_BYTES(ARENA_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (trk_ctrl),
    .need_i     (need),
    .cand_size_i(cand_size),
    .cand_off_i (rd_init_q ? '0 : rd_off_q),
    .cand_idx_i (p_idx_q),
    .cand_used_i(rd_used_q),
    .found_o    (found),
    .best_size_o(best_size),
    .best_off_o (best_off),
    .best_idx_o (best_idx)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    p_vld_d    = 1'b0;
    rd_en      = 1'b0;
    we         = 1'b0;
    waddr      = best_idx;
    wdata_off  = best_off;
    wdata_size = rest[AW-1:0];
    out_load   = 1'b0;
    status_d   = status_q;
    pay_d      = pay_q;
    trk_ctrl   = '{clr: 1'b0, cand_vld: p_vld_q};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          trk_ctrl.clr = 1'b1;
          idx_d        = '0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        p_vld_d = 1'b1;
        if (idx_q == count_q - 1'b1) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          pay_d    = '0;
          if (!found) begin
            status_d = STAT_NOFIT;
          end else if (count_q == CNT_MAX) begin
            status_d = STAT_FULL;
          end else begin
            status_d = STAT_GRANT;
            pay_d    = pay_full[OFF_W-1:0];
            we       = 1'b1;
            state_d  = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        we         = 1'b1;
        waddr      = count_q[IW-1:0];
        wdata_off  = hdr[AW-1:0];
        wdata_size = AW'(req_q);
        count_d    = count_q + 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_vld_d = out_load || (out_vld_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      count_q   <= CNTW'(1);
      used_q    <= '0;
      e0_init_q <= 1'b1;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
      p_vld_q   <= p_vld_d;
      out_vld_q <= out_vld_d;
      if (state_q == S_WRITE) begin
        used_q[count_q[IW-1:0]] <= 1'b1;
      end
      if (we && (waddr == '0)) begin
        e0_init_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= req_size_i;
    end
    if (out_load) begin
      status_q <= status_d;
      pay_q    <= pay_d;
    end
  end

  // Block table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      off_mem[waddr]  <= wdata_off;
      size_mem[waddr] <= wdata_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_off_q  <= off_mem[idx_q[IW-1:0]];
      rd_size_q <= size_mem[idx_q[IW-1:0]];
      rd_used_q <= used_q[idx_q[IW-1:0]];
      rd_init_q <= e0_init_q && (idx_q == '0);
      p_idx_q   <= idx_q[IW-1:0];
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_vld_q;
  assign status_o         = status_q;
  assign payload_offset_o = pay_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_MAX))
    else $error("entry count out of range");

  a_grant_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_d == STAT_GRANT) |=> (state_q == S_WRITE) ##1
    (count_q == $past(count_q, 2) + 1'b1))
    else $error("granted item did not add a table entry");

  a_grant_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_d == STAT_GRANT) |-> found)
    else $error("grant without a fitting block");

  a_idle_no_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DECIDE) |-> !p_vld_q)
    else $error("compare pending outside the scan");

endmodule
